### hdl/filtered_light_level_classifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the filtered light level classifier
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FILTERED_LIGHT_LEVEL_CLASSIFIER_ASSERT_SVH
`define FILTERED_LIGHT_LEVEL_CLASSIFIER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Shared widths, class codes, register indexes and the settings struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flc_pkg;

	localparam int unsigned DATA_W    = 10;
	localparam int unsigned CLASS_W   = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CLASS_W-1:0] CLASS_DARK  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_LIGHT = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_SUN   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SUN_THR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 2'd2;

	typedef logic [DATA_W-1:0]  level_t;
	typedef logic [CLASS_W-1:0] class_t;

	typedef struct packed {
		level_t light_thr;
		level_t sun_thr;
		level_t hyst;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/flc_filter.sv
// ----------------------------------------------------------------------------
// flc_filter
// One step of the integer exponential average:
// new = old + floor((sample - old) / WEIGHT), exact for any weight in range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flc_filter #(
	parameter int unsigned WEIGHT = 8
) (
	input  wire flc_pkg::level_t sample,
	input  wire flc_pkg::level_t level,
	output flc_pkg::level_t      next_level
);

	localparam int unsigned DW = flc_pkg::DATA_W;
	localparam int unsigned LW = $clog2(WEIGHT);
	// biased numerator stays below 2^NW
	localparam int unsigned NW = DW + 1 + LW;
	localparam int unsigned SH = NW + LW;
	localparam int unsigned MW = SH + 1;
	localparam int unsigned PW = NW + MW;
	// reciprocal rounded up; error times numerator stays below 2^SH
	localparam longint unsigned MUL = ((longint'(1) << SH) + longint'(WEIGHT) - 1)
		/ longint'(WEIGHT);
	localparam logic [NW-1:0]   OFFSET = NW'(longint'(WEIGHT) << DW);
	localparam logic [DW+1:0]   BIAS   = (DW + 2)'(1) << DW;

	logic signed [DW:0]   diff;
	logic        [NW-1:0] num;
	logic        [PW-1:0] prod;
	logic        [DW:0]   quot;
	logic        [DW+1:0] sum;

	// bias the signed difference positive so the divide floors correctly
	assign diff       = signed'({1'b0, sample}) - signed'({1'b0, level});
	assign num        = OFFSET + NW'(diff);
	assign prod       = PW'(num) * PW'(MW'(MUL));
	assign quot       = prod[SH +: DW + 1];
	assign sum        = {2'b00, level} + {1'b0, quot} - BIAS;
	assign next_level = sum[DW-1:0];

endmodule

`default_nettype wire

### hdl/flc_classify.sv
// ----------------------------------------------------------------------------
// flc_classify
// Threshold compare with hysteresis bands; keeps the old class inside a band.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module flc_classify (
	input  wire flc_pkg::level_t level,
	input  wire flc_pkg::class_t prev_class,
	input  wire flc_pkg::cfg_t   cfg,
	output flc_pkg::class_t      next_class
);

	localparam int unsigned CW = flc_pkg::DATA_W + 2;

	logic signed [CW-1:0] lvl;
	logic signed [CW-1:0] sun_hi;
	logic signed [CW-1:0] sun_lo;
	logic signed [CW-1:0] light_hi;
	logic signed [CW-1:0] light_lo;

	// signed compares: a band edge below zero never matches
	assign lvl      = signed'({2'b00, level});
	assign sun_hi   = signed'({2'b00, cfg.sun_thr})   + signed'({2'b00, cfg.hyst});
	assign sun_lo   = signed'({2'b00, cfg.sun_thr})   - signed'({2'b00, cfg.hyst});
	assign light_hi = signed'({2'b00, cfg.light_thr}) + signed'({2'b00, cfg.hyst});
	assign light_lo = signed'({2'b00, cfg.light_thr}) - signed'({2'b00, cfg.hyst});

	always_comb begin
		next_class = prev_class;
		if (lvl > sun_hi) begin
			next_class = flc_pkg::CLASS_SUN;
		end else if (lvl < sun_lo && lvl > light_hi) begin
			next_class = flc_pkg::CLASS_LIGHT;
		end else if (lvl < light_lo) begin
			next_class = flc_pkg::CLASS_DARK;
		end
	end

endmodule

`default_nettype wire

### hdl/filtered_light_level_classifier.sv
// ----------------------------------------------------------------------------
// filtered_light_level_classifier
// Smooths light sensor samples and classifies the level as dark, light or sun.
// ----------------------------------------------------------------------------
// Each 10-bit sample beat is smoothed by an integer exponential average of
// weight FILTER_WEIGHT (1 to 64) and the smoothed level is classified against
// the light and sun thresholds, each widened by +/- hysteresis; inside a band
// the previous class is kept. Every sample gives exactly one result beat
// carrying the class (0 dark, 1 light, 2 sun) and the filtered level. The
// block takes one sample per clock unless the result channel stalls: a sample
// is captured in the input register and its result in the output register.
// The rate is set by the filter feedback loop through the level register (one
// constant multiply and the band compares). Both start from zero level and
// class dark after reset. Thresholds and hysteresis are written through the
// cfg port (index 0 light threshold, 1 sun threshold, 2 hysteresis; other
// indexes are dropped); cfg_ready is always high. The user must write them
// only while no sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "filtered_light_level_classifier_assert.svh"

module filtered_light_level_classifier #(
	parameter int unsigned FILTER_WEIGHT = 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// sample channel
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [flc_pkg::DATA_W-1:0]          sample,
	// result channel
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [flc_pkg::CLASS_W-1:0]         light_class,
	output logic [flc_pkg::DATA_W-1:0]          filtered_value,
	// settings write channel
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [flc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [flc_pkg::DATA_W-1:0]          cfg_data
);

	// settings
	flc_pkg::cfg_t   cfg_q;

	// input register
	logic            valid_s1;
	flc_pkg::level_t sample_s1;

	// result register; it also holds the filter and class state
	logic            out_valid_q;
	flc_pkg::level_t level_q;
	flc_pkg::class_t class_q;

	// handshake
	logic            out_take;
	logic            adv_s1;

	flc_pkg::level_t next_level;
	flc_pkg::class_t next_class;

	// used by the checks only
	logic [flc_pkg::DATA_W:0] sun_hi_chk;

	// Advance the input stage whenever the result register is empty or drains.
	assign out_take  = !out_valid_q || out_ready;
	assign adv_s1    = valid_s1 && out_take;
	assign in_ready  = !valid_s1 || out_take;
	assign cfg_ready = 1'b1;

	assign out_valid      = out_valid_q;
	assign filtered_value = level_q;
	assign light_class    = class_q;

	// Write settings; drop writes to unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				flc_pkg::CFG_LIGHT_THR: cfg_q.light_thr <= cfg_data;
				flc_pkg::CFG_SUN_THR:   cfg_q.sun_thr   <= cfg_data;
				flc_pkg::CFG_HYST:      cfg_q.hyst      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: load a new beat whenever the stage is free or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
		end
	end

	flc_filter #(
		.WEIGHT (FILTER_WEIGHT)
	) u_filter (
		.sample     (sample_s1),
		.level      (level_q),
		.next_level (next_level)
	);

	flc_classify u_classify (
		.level      (next_level),
		.prev_class (class_q),
		.cfg        (cfg_q),
		.next_class (next_class)
	);

	// Result stage: the state moves only when a result is loaded, so a
	// stalled result keeps the filter and class where they were.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			level_q     <= '0;
			class_q     <= flc_pkg::CLASS_DARK;
		end else begin
			if (out_take) begin
				out_valid_q <= valid_s1;
			end
			if (adv_s1) begin
				level_q <= next_level;
				class_q <= next_class;
			end
		end
	end

	assign sun_hi_chk = {1'b0, cfg_q.sun_thr} + {1'b0, cfg_q.hyst};

	`FLC_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1,
		"accepted sample beat did not reach the input stage")
	`FLC_ASSERT_NEXT(a_adv_gives_result, adv_s1, out_valid,
		"advanced sample produced no result beat")
	`FLC_ASSERT_SAME(a_stall_holds_s1, valid_s1 && out_valid_q && !out_ready, !adv_s1,
		"input stage advanced into a stalled result register")
	`FLC_ASSERT_NEXT(a_level_between, adv_s1,
		(filtered_value >= $past(level_q) && filtered_value <= $past(sample_s1)) ||
		(filtered_value <= $past(level_q) && filtered_value >= $past(sample_s1)),
		"filtered level left the span between old level and sample")
	`FLC_ASSERT_NEXT(a_sun_above_band, adv_s1 && ({1'b0, next_level} > sun_hi_chk),
		light_class == flc_pkg::CLASS_SUN,
		"level above the sun band not classified as sun")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the filtered light level classifier.
// ----------------------------------------------------------------------------
// Sample beats go in over a valid/ready channel with random gaps, result beats
// are taken with random back-pressure, and the settings are rewritten between
// phases once the block has drained. A small tracker class keeps its own copy
// of the smoothed level, the class and the settings, predicts the result of
// every accepted sample and compares each result beat against the oldest
// prediction. A short directed part walks the level up through both bands and
// back down, tries thresholds that are inverted or lie inside the band, and
// may write the unused register index. The random part then feeds runs of
// samples around random targets so that the level settles near the thresholds
// and the kept-class behaviour inside the bands is exercised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

	import flc_pkg::*;

	localparam int unsigned FILTER_WEIGHT = 8;
	localparam int unsigned LATENCY       = 2;
	localparam int unsigned LIMIT_CYCLES  = 200000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS   = 105;

	// Index with no register behind it: the block drops such writes.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam level_t LEVEL_MAX = 10'd1023;

	typedef struct packed {
		class_t cls;
		level_t level;
	} reading_t;

	// ------------------------------------------------------------------------
	// Tracker: predicts the class and smoothed level for every accepted sample
	// and checks result beats against the oldest prediction.
	// ------------------------------------------------------------------------
	class light_class_tracker;
		level_t   light_thr = '0;
		level_t   sun_thr   = '0;
		level_t   hyst      = '0;
		level_t   level     = '0;
		class_t   cls       = CLASS_DARK;
		reading_t expected_readings[$];
		int       errors    = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, level_t data);
			case (idx)
				CFG_LIGHT_THR: light_thr = data;
				CFG_SUN_THR:   sun_thr   = data;
				CFG_HYST:      hyst      = data;
				default:       ;
			endcase
		endfunction

		function void note_sample(level_t s);
			int unsigned acc;
			int          lvl, sun_hi, sun_lo, light_hi, light_lo;
			acc   = (FILTER_WEIGHT - 1) * int'(level) + int'(s);
			level = level_t'(acc / FILTER_WEIGHT);
			lvl      = int'(level);
			sun_hi   = int'(sun_thr) + int'(hyst);
			sun_lo   = int'(sun_thr) - int'(hyst);
			light_hi = int'(light_thr) + int'(hyst);
			light_lo = int'(light_thr) - int'(hyst);
			// Sun test first; inside a band nothing matches and the class holds.
			if (lvl > sun_hi) begin
				cls = CLASS_SUN;
			end else if (lvl < sun_lo && lvl > light_hi) begin
				cls = CLASS_LIGHT;
			end else if (lvl < light_lo) begin
				cls = CLASS_DARK;
			end
			expected_readings.push_back('{cls: cls, level: level});
		endfunction

		function void report(string what, int expected, int actual);
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d",
				$time, what, expected, actual);
		endfunction

		function void check_reading(class_t got_cls, level_t got_level);
			reading_t want;
			if (expected_readings.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, got class %0d level %0d",
					$time, got_cls, got_level);
				return;
			end
			want = expected_readings.pop_front();
			if (got_cls !== want.cls) begin
				report("light_class", want.cls, got_cls);
			end
			if (got_level !== want.level) begin
				report("filtered_value", want.level, got_level);
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and the block's ports
	// ------------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	level_t               sample    = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	class_t               light_class;
	level_t               filtered_value;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	level_t               cfg_data  = '0;

	// Largest gap the sender and largest stall the receiver may draw per beat;
	// set per phase so that some stretches run with no idling at all.
	int unsigned tx_gap_max   = 5;
	int unsigned rx_stall_max = 5;
	int unsigned cycles       = 0;

	light_class_tracker tracker;

	filtered_light_level_classifier #(
		.FILTER_WEIGHT(FILTER_WEIGHT)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.light_class   (light_class),
		.filtered_value(filtered_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Monitor: everything driven by the bench changes through nonblocking
	// assignments, so values read here are the ones the block saw at this edge.
	// ------------------------------------------------------------------------
	initial tracker = new;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				tracker.write_reg(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				tracker.note_sample(sample);
			end
			if (out_valid && out_ready) begin
				tracker.check_reading(light_class, filtered_value);
			end
		end
	end

	// Watchdog: give up well past the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: draw a stall for each result beat, then hold ready until a beat
	// is taken.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = $urandom_range(0, rx_stall_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Send one sample beat. Entered at the edge that took the previous beat;
	// with no gap, valid simply stays high and only the payload moves on.
	task automatic push_sample(input level_t s);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// Write one register; the caller drops cfg_valid after its last write.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input level_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_settings(input level_t light_thr, input level_t sun_thr,
			input level_t hyst);
		cfg_write(CFG_LIGHT_THR, light_thr);
		cfg_write(CFG_SUN_THR, sun_thr);
		cfg_write(CFG_HYST, hyst);
		// Occasionally poke the unused index; the predictor ignores it too.
		if ($urandom_range(0, 2) == 0) begin
			cfg_write(CFG_UNUSED, level_t'($urandom_range(0, LEVEL_MAX)));
		end
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait until every predicted reading has come back, then
	// allow the pipeline latency before the settings may change.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Pick settings for a random phase: ordinary ordered thresholds, corner
	// values, inverted thresholds or anything at all.
	task automatic random_settings();
		level_t lo, hi, hy;
		lo = level_t'($urandom_range(0, LEVEL_MAX));
		hi = level_t'($urandom_range(0, LEVEL_MAX));
		hy = level_t'($urandom_range(0, 60));
		case ($urandom_range(0, 4))
			0: write_settings((lo < hi) ? lo : hi, (lo < hi) ? hi : lo, hy);
			1: write_settings($urandom_range(0, 1) ? LEVEL_MAX : '0,
				$urandom_range(0, 1) ? LEVEL_MAX : '0,
				$urandom_range(0, 1) ? LEVEL_MAX : '0);
			2: write_settings((lo > hi) ? lo : hi, (lo > hi) ? hi : lo, hy);
			3: write_settings(lo, hi, level_t'($urandom_range(0, LEVEL_MAX)));
			default: write_settings((lo < hi) ? lo : hi, (lo < hi) ? hi : lo, '0);
		endcase
	endtask

	// Runs of samples around a random target let the level settle near the
	// thresholds; full-range noise and extreme swings fill the rest.
	task automatic random_samples(input int unsigned count);
		int unsigned sent, run_len, kind;
		int          target, spread, s;
		sent = 0;
		while (sent < count) begin
			kind    = $urandom_range(0, 9);
			run_len = $urandom_range(4, 24);
			target  = $urandom_range(0, LEVEL_MAX);
			spread  = $urandom_range(0, 40);
			for (int i = 0; i < run_len && sent < count; i++) begin
				if (kind == 0) begin
					s = $urandom_range(0, LEVEL_MAX);
				end else if (kind == 1) begin
					s = (i % 2 == 0) ? int'(LEVEL_MAX) : 0;
				end else begin
					s = target + int'($urandom_range(0, 2 * spread)) - spread;
					s = (s < 0) ? 0 : ((s > int'(LEVEL_MAX)) ? int'(LEVEL_MAX) : s);
				end
				push_sample(level_t'(s));
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every threshold and the band are zero, so any
		// level above zero is sun and nothing ever pulls it back.
		push_sample('0);
		push_sample(LEVEL_MAX);
		push_sample(LEVEL_MAX);
		push_sample('0);
		drain();

		// Ordinary bands: climb from dark through light to sun, holding the
		// class inside each band, then fall back to dark. Back-to-back beats.
		tx_gap_max = 0;
		write_settings(10'd200, 10'd500, 10'd50);
		repeat (7) push_sample(LEVEL_MAX);
		repeat (12) push_sample('0);
		drain();

		// Inverted thresholds with the widest band: the lower edges go
		// negative and the class can only hold.
		tx_gap_max = 5;
		write_settings(10'd600, 10'd100, LEVEL_MAX);
		push_sample(LEVEL_MAX);
		push_sample('0);
		push_sample(10'h155);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_gap_max   = (p % 3 == 1) ? 0 : 5;
			rx_stall_max = (p % 4 == 2) ? 0 : 5;
			random_settings();
			random_samples(PHASE_ITEMS);
			drain();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
